@@ sv/chgs_pkg.sv @@
// Shared types and constants for the Graham scan convex hull block.
`default_nettype none
package chgs_pkg;
	localparam int MinHull = 3;

	// Sequencer state codes.
	localparam logic [5:0] ST_LOAD     = 6'd0;
	localparam logic [5:0] ST_EMPTY    = 6'd1;
	localparam logic [5:0] ST_PIV_RD   = 6'd2;
	localparam logic [5:0] ST_PIV_CMP  = 6'd3;
	localparam logic [5:0] ST_SW_RDA   = 6'd4;
	localparam logic [5:0] ST_SW_RDB   = 6'd5;
	localparam logic [5:0] ST_SW_WRA   = 6'd6;
	localparam logic [5:0] ST_SW_WRB   = 6'd7;
	localparam logic [5:0] ST_SRT_KRD  = 6'd8;
	localparam logic [5:0] ST_SRT_KLD  = 6'd9;
	localparam logic [5:0] ST_SRT_JLD  = 6'd10;
	localparam logic [5:0] ST_SRT_C1   = 6'd11;
	localparam logic [5:0] ST_SRT_C2   = 6'd12;
	localparam logic [5:0] ST_SRT_C3   = 6'd13;
	localparam logic [5:0] ST_SRT_D1   = 6'd14;
	localparam logic [5:0] ST_SRT_D2   = 6'd15;
	localparam logic [5:0] ST_SRT_D3   = 6'd16;
	localparam logic [5:0] ST_SRT_D4   = 6'd17;
	localparam logic [5:0] ST_SRT_DEC  = 6'd18;
	localparam logic [5:0] ST_SCN_SEED = 6'd19;
	localparam logic [5:0] ST_SCN_IRD  = 6'd20;
	localparam logic [5:0] ST_SCN_ILD  = 6'd21;
	localparam logic [5:0] ST_SCN_S1   = 6'd22;
	localparam logic [5:0] ST_SCN_S2   = 6'd23;
	localparam logic [5:0] ST_SCN_S3   = 6'd24;
	localparam logic [5:0] ST_SCN_S4   = 6'd25;
	localparam logic [5:0] ST_SCN_C1   = 6'd26;
	localparam logic [5:0] ST_SCN_C2   = 6'd27;
	localparam logic [5:0] ST_SCN_C3   = 6'd28;
	localparam logic [5:0] ST_SCN_DEC  = 6'd29;
	localparam logic [5:0] ST_SCN_PUSH = 6'd30;
	localparam logic [5:0] ST_OUT_SRD  = 6'd31;
	localparam logic [5:0] ST_OUT_PRD  = 6'd32;
	localparam logic [5:0] ST_OUT_EM   = 6'd33;

	// Operations of the shared multiply-accumulate unit.
	typedef enum logic [1:0] {
		MAC_LOAD = 2'd0,
		MAC_ADD  = 2'd1,
		MAC_SUB  = 2'd2
	} mac_op_t;
endpackage
`default_nettype wire

@@ sv/chgs_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module chgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ sv/chgs_mac.sv @@
// Shared multiplier with accumulator: one signed product per cycle.
`default_nettype none
module chgs_mac import chgs_pkg::*; #(
	parameter int OPW = 17,
	parameter int ACCW = 36
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire mac_op_t                op,
	input  wire logic signed [OPW-1:0]  a,
	input  wire logic signed [OPW-1:0]  b,
	output logic signed [ACCW-1:0]      acc
);
	logic signed [2*OPW-1:0] prod_s1;
	logic signed [ACCW-1:0]  prod_ext;

	assign prod_ext = ACCW'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (en) begin
			unique case (op)
				MAC_LOAD: acc <= prod_ext;
				MAC_ADD:  acc <= acc + prod_ext;
				MAC_SUB:  acc <= acc - prod_ext;
				default:  acc <= acc;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/convex_hull_graham_scan.sv @@
// Top level of the Graham scan convex hull block: sequencer, point and stack memories.
`default_nettype none
// Usage: points are sent one beat at a time with start high while busy is low.
// Each accepted beat writes one point into the point memory, so a set streams
// in at one point per clock. The beat with last_point high ends the set; busy
// then rises and the block finds the pivot, selection-sorts the points by polar
// angle and runs the Graham scan, all through a single shared multiplier fed
// from one single-port point memory.
// Run time: the pivot search reads every point once, the swaps and the sort
// run per position with one comparison for each later candidate, so the sort
// grows with n*n. The scan seeds the stack, then reads each further point and
// tests turns against the stack top, popping until the new point is pushed;
// the output reads each vertex through the stack. The sort dominates.
// Results: each hull vertex appears for one cycle with strobe high; the last
// one carries last_vertex and busy is already low in that cycle. A set of
// fewer than three points goes to ST_EMPTY, which gives one beat with hull_empty
// high. The receiver cannot stall, so every result is final when shown. Points
// past capacity are dropped and flagged by overflowed.
// Reset: arst_n clears the sequencer, counts and flags; memory contents are
// not cleared, since every entry is written before it is read within a set.
module convex_hull_graham_scan import chgs_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic        last_point,
	output logic             strobe,
	output logic signed [15:0] hull_x,
	output logic signed [15:0] hull_y,
	output logic             last_vertex,
	output logic             hull_empty,
	output logic             overflowed
);
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int DW   = COORD_BITS + 1;
	localparam int ACCW = 2 * DW + 2;

	typedef logic signed [COORD_BITS-1:0] crd_t;

	logic [5:0]       state_q;
	logic [CW-1:0]    count_q;
	logic             ovf_q;
	logic [CW-1:0]    top_q;
	logic [CW-1:0]    i_q, j_q, k_q;
	crd_t             px_q, py_q;     // pivot
	crd_t             kx_q, ky_q;     // current best / stack top
	crd_t             jx_q, jy_q;     // candidate / new point
	crd_t             ux_q, uy_q;     // stack second
	crd_t             ax_q, ay_q;     // swap buffer
	logic signed [ACCW-1:0] cr_q;
	logic signed [ACCW-1:0] dj_q;
	logic             load_ok;
	logic [CW-1:0]    n_next;

	// Point memory.
	logic             pm_we;
	logic [AW-1:0]    pm_addr;
	logic [2*COORD_BITS-1:0] pm_wdata, pm_rdata;
	crd_t             rd_x, rd_y;
	assign rd_x = pm_rdata[2*COORD_BITS-1:COORD_BITS];
	assign rd_y = pm_rdata[COORD_BITS-1:0];

	chgs_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_pts (
		.clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata));

	// Stack memory of point indices.
	logic             sm_we;
	logic [AW-1:0]    sm_addr, sm_wdata, sm_rdata;

	chgs_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_stk (
		.clk(clk), .we(sm_we), .addr(sm_addr), .wdata(sm_wdata), .rdata(sm_rdata));

	// Shared multiplier.
	logic             mac_en;
	mac_op_t          mac_op;
	logic signed [DW-1:0] mac_a, mac_b;
	logic signed [ACCW-1:0] acc;

	chgs_mac #(.OPW(DW), .ACCW(ACCW)) u_mac (
		.clk(clk), .en(mac_en), .op(mac_op), .a(mac_a), .b(mac_b), .acc(acc));

	function automatic logic signed [DW-1:0] dif(input crd_t p, input crd_t q);
		dif = DW'(p) - DW'(q);
	endfunction

	// The low COORD_BITS bits of a coordinate port, read as two's complement.
	function automatic crd_t to_crd(input logic [15:0] raw);
		to_crd = COORD_BITS'(raw);
	endfunction

	assign busy    = (state_q != ST_LOAD);
	assign load_ok = (count_q < CW'(MAX_POINTS));
	assign n_next  = load_ok ? count_q + CW'(1) : count_q;

	// Memory, multiplier and operand control. The product register holds a*b
	// of the previous cycle, so operands are presented in the cycle before the
	// accumulate step that consumes them.
	always_comb begin
		pm_we    = 1'b0;
		pm_addr  = i_q[AW-1:0];
		pm_wdata = {ax_q, ay_q};
		sm_we    = 1'b0;
		sm_addr  = top_q[AW-1:0];
		sm_wdata = i_q[AW-1:0];
		mac_en   = 1'b0;
		mac_op   = MAC_LOAD;
		mac_a    = '0;
		mac_b    = '0;
		unique case (state_q)
			ST_LOAD: begin
				pm_we    = start && load_ok;
				pm_addr  = count_q[AW-1:0];
				pm_wdata = {to_crd(point_x), to_crd(point_y)};
			end
			ST_SW_RDB: pm_addr = k_q[AW-1:0];
			ST_SW_WRA: begin
				pm_we = 1'b1; pm_addr = i_q[AW-1:0]; pm_wdata = {rd_x, rd_y};
			end
			ST_SW_WRB: begin
				pm_we = 1'b1; pm_addr = k_q[AW-1:0]; pm_wdata = {ax_q, ay_q};
			end
			ST_SRT_KRD: pm_addr = k_q[AW-1:0];
			ST_SRT_KLD: pm_addr = j_q[AW-1:0];
			ST_SRT_C1: begin
				mac_a = dif(jx_q, px_q); mac_b = dif(ky_q, py_q);
			end
			ST_SRT_C2: begin
				mac_en = 1'b1; mac_op = MAC_LOAD;
				mac_a = dif(kx_q, px_q); mac_b = dif(jy_q, py_q);
			end
			ST_SRT_C3: begin
				mac_en = 1'b1; mac_op = MAC_SUB;
				mac_a = dif(jx_q, px_q); mac_b = dif(jx_q, px_q);
			end
			ST_SRT_D1: begin
				mac_en = 1'b1; mac_op = MAC_LOAD;
				mac_a = dif(jy_q, py_q); mac_b = dif(jy_q, py_q);
			end
			ST_SRT_D2: begin
				mac_en = 1'b1; mac_op = MAC_ADD;
				mac_a = dif(kx_q, px_q); mac_b = dif(kx_q, px_q);
			end
			ST_SRT_D3: begin
				mac_en = 1'b1; mac_op = MAC_LOAD;
				mac_a = dif(ky_q, py_q); mac_b = dif(ky_q, py_q);
			end
			ST_SRT_D4: begin
				mac_en = 1'b1; mac_op = MAC_ADD;
			end
			// Fetch the next candidate while the decision is taken.
			ST_SRT_DEC: pm_addr = AW'(j_q + CW'(1));
			ST_SCN_SEED: begin
				sm_we = 1'b1; sm_addr = j_q[AW-1:0]; sm_wdata = j_q[AW-1:0];
			end
			ST_SCN_S1: sm_addr = AW'(top_q - CW'(1));
			ST_SCN_S2: begin
				sm_addr = AW'(top_q - CW'(2));
				pm_addr = sm_rdata;
			end
			ST_SCN_S3: pm_addr = sm_rdata;
			ST_SCN_C1: begin
				mac_a = dif(jx_q, ux_q); mac_b = dif(ky_q, uy_q);
			end
			ST_SCN_C2: begin
				mac_en = 1'b1; mac_op = MAC_LOAD;
				mac_a = dif(kx_q, ux_q); mac_b = dif(jy_q, uy_q);
			end
			ST_SCN_C3: begin
				mac_en = 1'b1; mac_op = MAC_SUB;
			end
			ST_SCN_PUSH: sm_we = 1'b1;
			ST_OUT_SRD: sm_addr = i_q[AW-1:0];
			ST_OUT_PRD: pm_addr = sm_rdata;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			top_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			px_q        <= '0;
			py_q        <= '0;
			kx_q        <= '0;
			ky_q        <= '0;
			jx_q        <= '0;
			jy_q        <= '0;
			ux_q        <= '0;
			uy_q        <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			cr_q        <= '0;
			dj_q        <= '0;
			strobe      <= 1'b0;
			hull_x      <= '0;
			hull_y      <= '0;
			last_vertex <= 1'b0;
			hull_empty  <= 1'b0;
			overflowed  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (load_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						// A dropped point that ends the set still ends it.
						if (last_point) begin
							i_q     <= '0;
							state_q <= (n_next < CW'(MinHull)) ? ST_EMPTY : ST_PIV_RD;
						end
					end
				end
				ST_EMPTY: begin
					strobe      <= 1'b1;
					hull_x      <= '0;
					hull_y      <= '0;
					last_vertex <= 1'b1;
					hull_empty  <= 1'b1;
					overflowed  <= ovf_q;
					count_q     <= '0;
					ovf_q       <= 1'b0;
					state_q     <= ST_LOAD;
				end
				// Pivot search: read point i, compare with the lowest so far.
				ST_PIV_RD: state_q <= ST_PIV_CMP;
				ST_PIV_CMP: begin
					if (i_q == '0 || rd_y < py_q || (rd_y == py_q && rd_x < px_q)) begin
						px_q <= rd_x; py_q <= rd_y; k_q <= i_q;
					end
					if (i_q + CW'(1) == count_q) begin
						i_q     <= '0;
						state_q <= ST_SW_RDA;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_PIV_RD;
					end
				end
				// Swap point i with point k through the single port.
				ST_SW_RDA: state_q <= ST_SW_RDB;
				ST_SW_RDB: begin
					ax_q <= rd_x; ay_q <= rd_y;
					state_q <= ST_SW_WRA;
				end
				ST_SW_WRA: state_q <= ST_SW_WRB;
				ST_SW_WRB: begin
					if (i_q + CW'(2) < count_q) begin
						i_q     <= i_q + CW'(1);
						k_q     <= i_q + CW'(1);
						j_q     <= i_q + CW'(2);
						state_q <= ST_SRT_KRD;
					end else begin
						// Sort finished: seed the stack with points 0, 1 and 2.
						j_q     <= '0;
						state_q <= ST_SCN_SEED;
					end
				end
				ST_SRT_KRD: state_q <= ST_SRT_KLD;
				ST_SRT_KLD: begin
					kx_q <= rd_x; ky_q <= rd_y;
					state_q <= ST_SRT_JLD;
				end
				ST_SRT_JLD: begin
					jx_q <= rd_x; jy_q <= rd_y;
					state_q <= ST_SRT_C1;
				end
				// Candidate j against best k: cross product, then both distances.
				ST_SRT_C1: state_q <= ST_SRT_C2;
				ST_SRT_C2: state_q <= ST_SRT_C3;
				ST_SRT_C3: state_q <= ST_SRT_D1;
				ST_SRT_D1: begin
					cr_q    <= acc;
					state_q <= ST_SRT_D2;
				end
				ST_SRT_D2: state_q <= ST_SRT_D3;
				ST_SRT_D3: begin
					dj_q    <= acc;
					state_q <= ST_SRT_D4;
				end
				ST_SRT_D4: state_q <= ST_SRT_DEC;
				ST_SRT_DEC: begin
					// acc holds |k-p|^2, dj_q holds |j-p|^2.
					if (cr_q > 0 || (cr_q == 0 && dj_q < acc)) begin
						k_q <= j_q; kx_q <= jx_q; ky_q <= jy_q;
					end
					if (j_q + CW'(1) < count_q) begin
						j_q     <= j_q + CW'(1);
						state_q <= ST_SRT_JLD;
					end else begin
						state_q <= ST_SW_RDA;
					end
				end
				ST_SCN_SEED: begin
					if (j_q == CW'(2)) begin
						top_q <= CW'(3);
						if (count_q == CW'(3)) begin
							i_q     <= '0;
							state_q <= ST_OUT_SRD;
						end else begin
							i_q     <= CW'(3);
							state_q <= ST_SCN_IRD;
						end
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				// Scan: new point i, then the two points on top of the stack.
				ST_SCN_IRD: state_q <= ST_SCN_ILD;
				ST_SCN_ILD: begin
					jx_q <= rd_x; jy_q <= rd_y;
					state_q <= ST_SCN_S1;
				end
				ST_SCN_S1: state_q <= ST_SCN_S2;
				ST_SCN_S2: state_q <= ST_SCN_S3;
				ST_SCN_S3: begin
					kx_q <= rd_x; ky_q <= rd_y;
					state_q <= ST_SCN_S4;
				end
				ST_SCN_S4: begin
					ux_q <= rd_x; uy_q <= rd_y;
					state_q <= ST_SCN_C1;
				end
				ST_SCN_C1: state_q <= ST_SCN_C2;
				ST_SCN_C2: state_q <= ST_SCN_C3;
				ST_SCN_C3: state_q <= ST_SCN_DEC;
				ST_SCN_DEC: begin
					// Anything but a strict left turn pops, down to two points.
					if (acc >= 0) begin
						top_q   <= top_q - CW'(1);
						state_q <= (top_q > CW'(3)) ? ST_SCN_S1 : ST_SCN_PUSH;
					end else begin
						state_q <= ST_SCN_PUSH;
					end
				end
				ST_SCN_PUSH: begin
					top_q <= top_q + CW'(1);
					if (i_q + CW'(1) == count_q) begin
						i_q     <= '0;
						state_q <= ST_OUT_SRD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_SCN_IRD;
					end
				end
				ST_OUT_SRD: state_q <= ST_OUT_PRD;
				ST_OUT_PRD: state_q <= ST_OUT_EM;
				ST_OUT_EM: begin
					strobe      <= 1'b1;
					hull_x      <= 16'(rd_x);
					hull_y      <= 16'(rd_y);
					hull_empty  <= 1'b0;
					overflowed  <= ovf_q;
					last_vertex <= (i_q + CW'(1) == top_q);
					if (i_q + CW'(1) == top_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						top_q   <= '0;
						state_q <= ST_LOAD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_OUT_SRD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/chgs_checker.sv @@
// Port-level checker for the convex hull block, bound to the top level.
`default_nettype none
module chgs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic last_point,
	input wire logic strobe,
	input wire logic last_vertex,
	input wire logic hull_empty
);
	// An empty-hull beat always carries last_vertex: it is the only beat of its set.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && hull_empty |-> last_vertex)
		else $error("empty hull beat without last_vertex");

	// A result only appears while the block is working on a set.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat while idle");

	// An accepted last point makes the block busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_point |=> busy)
		else $error("last point did not start hull computation");

	// The final vertex ends the set: in the cycle that shows the
	// final vertex the block is already ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_vertex |-> !busy)
		else $error("block still busy after final vertex");
endmodule

bind convex_hull_graham_scan chgs_checker u_chgs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .last_point(last_point),
	.strobe(strobe), .last_vertex(last_vertex), .hull_empty(hull_empty));
`default_nettype wire
